@@ rtl/core/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the rc4 stream cipher core: commands,
// controller states and the permutation memory request.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PermDepth = 256;
  localparam logic [ByteW-1:0] ByteMax = '1;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [1:0] {
    CMD_KEY_WRITE = 2'd0,
    CMD_SCHEDULE  = 2'd1,
    CMD_DATA      = 2'd2
  } rc4_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J
  } rc4_state_e;

  typedef struct packed {
    logic  clear;
    logic  re;
    byte_t raddr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
  } perm_req_t;

endpackage

@@ rtl/core/rc4_stream_if.sv @@
// ----------------------------------------------------------------------------
// rc4 stream interfaces
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] key_index;
  logic [7:0] key_byte;
  logic [7:0] key_length_minus_one;
  logic [7:0] data_byte;

  modport source (
    output valid, command, key_index, key_byte, key_length_minus_one, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, key_index, key_byte, key_length_minus_one, data_byte,
    output ready
  );
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (
    output valid, out_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte,
    output ready
  );
endinterface

@@ rtl/core/rc4_stream_cipher_core.sv @@
// data: an item passes ST_GEN_RD_J, ST_GEN_WR_I and ST_GEN_WR_J, which
//   waits for a free result register; the read-swap-read sequence on the
//   permutation memory, with its single read and single write port, ends
//   before a new item is taken; key schedule: four memory steps per swap
// key write and unused commands complete in ST_IDLE
// reset: asynchronous, active low; permutation reads as identity, indices zero
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 engine: key store, key schedule and keystream generator around one
// permutation memory.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core import rc4_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rc4_in_if.sink    in_i,
  rc4_out_if.source out_o
);

  localparam int unsigned KeyAw = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [ByteW:0] KeyMax = (ByteW+1)'(KEY_DEPTH - 1);

  rc4_state_e state_q, state_d;
  perm_req_t  perm_req;
  byte_t      perm_rd;

  byte_t      key_mem [KEY_DEPTH];
  byte_t      key_rd_q;
  logic       key_re;

  byte_t      i_q, j_q;
  logic [KeyAw-1:0] k_q, klast_q;
  byte_t      si_q, sj_q, t_q, data_q;
  logic       out_valid_q;
  byte_t      out_byte_q;

  logic       in_accept;
  logic       out_free;
  rc4_cmd_e   cmd;
  byte_t      ks_sum;
  byte_t      keystream;
  logic [ByteW:0] klen_ext;
  logic [ByteW:0] klen_sat;

  assign cmd       = rc4_cmd_e'(in_i.command);
  assign in_accept = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign ks_sum    = j_q + perm_rd + key_rd_q;
  assign klen_ext  = {1'b0, in_i.key_length_minus_one};
  assign klen_sat  = (klen_ext > KeyMax) ? KeyMax : klen_ext;

  always_comb begin
    if (t_q == j_q) begin
      keystream = si_q;
    end else if (t_q == i_q) begin
      keystream = sj_q;
    end else begin
      keystream = perm_rd;
    end
  end

  rc4_sbox u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (cmd)
            CMD_SCHEDULE: state_d = ST_KS_RD_N;
            CMD_DATA:     state_d = ST_GEN_RD_J;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_KS_RD_N:  state_d = ST_KS_RD_J;
      ST_KS_RD_J:  state_d = ST_KS_WR_N;
      ST_KS_WR_N:  state_d = ST_KS_WR_J;
      ST_KS_WR_J:  state_d = (i_q == ByteMax) ? ST_IDLE : ST_KS_RD_N;
      ST_GEN_RD_J: state_d = ST_GEN_WR_I;
      ST_GEN_WR_I: state_d = ST_GEN_WR_J;
      ST_GEN_WR_J: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory requests and handshake
  always_comb begin
    perm_req   = '0;
    key_re     = 1'b0;
    in_i.ready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && cmd == CMD_DATA) begin
          perm_req.re    = 1'b1;
          perm_req.raddr = i_q + 8'd1;
        end
        if (in_i.valid && cmd == CMD_SCHEDULE) begin
          perm_req.clear = 1'b1;
        end
      end
      ST_KS_RD_N: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = i_q;
        key_re         = 1'b1;
      end
      ST_KS_RD_J: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = ks_sum;
      end
      ST_KS_WR_N: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rd;
      end
      ST_KS_WR_J: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_q;
        perm_req.wdata = si_q;
      end
      ST_GEN_RD_J: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = j_q + perm_rd;
      end
      ST_GEN_WR_I: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rd;
        perm_req.re    = 1'b1;
        perm_req.raddr = si_q + perm_rd;
      end
      ST_GEN_WR_J: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_q;
        perm_req.wdata = si_q;
      end
      default: ;
    endcase
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (in_accept && cmd == CMD_KEY_WRITE && {1'b0, in_i.key_index} <= KeyMax) begin
      key_mem[in_i.key_index[KeyAw-1:0]] <= in_i.key_byte;
    end
    if (key_re) begin
      key_rd_q <= key_mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      klast_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_GEN_WR_J && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && cmd == CMD_SCHEDULE) begin
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            klast_q <= klen_sat[KeyAw-1:0];
          end else if (in_accept && cmd == CMD_DATA) begin
            i_q <= i_q + 8'd1;
          end
        end
        ST_KS_RD_J:  j_q <= ks_sum;
        ST_KS_WR_J: begin
          i_q <= i_q + 8'd1;
          k_q <= (k_q == klast_q) ? '0 : k_q + 1'b1;
          if (i_q == ByteMax) begin
            j_q <= '0;
          end
        end
        ST_GEN_RD_J: j_q <= j_q + perm_rd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= in_i.data_byte;
    end
    if (state_q == ST_KS_RD_J || state_q == ST_GEN_RD_J) begin
      si_q <= perm_rd;
    end
    if (state_q == ST_GEN_WR_I) begin
      sj_q <= perm_rd;
      t_q  <= si_q + perm_rd;
    end
    if (state_q == ST_GEN_WR_J && out_free) begin
      out_byte_q <= data_q ^ keystream;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

`ifndef NO_ASSERTIONS
  a_no_write_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(perm_req.clear && perm_req.we))
    else $error("permutation cleared and written in one cycle");

  a_schedule_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd == CMD_SCHEDULE) |=> (state_q == ST_KS_RD_N))
    else $error("key schedule did not start");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_GEN_WR_J))
    else $error("result raised outside the generator");

  a_schedule_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_WR_J && i_q == ByteMax) |=> (i_q == '0 && j_q == '0))
    else $error("indices not cleared after key schedule");
`endif

endmodule

@@ rtl/core/rc4_sbox.sv @@
// ----------------------------------------------------------------------------
// rc4_sbox
// Permutation memory, 256 x 8, one read and one write port, registered read.
// Per-entry valid bits make an unwritten entry read as its own index, so
// reset and the start of a key schedule restore the identity at once.
// ----------------------------------------------------------------------------
module rc4_sbox import rc4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  perm_req_t req_i,
  output byte_t     rdata_o
);

  byte_t                mem [PermDepth];
  logic [PermDepth-1:0] valid_q;
  byte_t                rdata_q;
  byte_t                raddr_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q  <= mem[req_i.raddr];
      raddr_q  <= req_i.raddr;
      rvalid_q <= valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : raddr_q;

endmodule

@@ sim/rc4_stream_cipher_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_checker
// Watches the command and result channels of the rc4 core, keeps its own
// permutation, key store and generator indices, and compares every result
// byte with the oldest predicted cipher byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_checker import rc4_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rc4_in_if           in_mon,
  rc4_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  byte_t sbox    [PermDepth];
  byte_t key_mem [PermDepth];
  byte_t idx_i;
  byte_t idx_j;
  byte_t cipher_bytes_q [$];
  byte_t expected_byte;

  function automatic void run_key_schedule(int unsigned key_len);
    byte_t       j;
    byte_t       t;
    int unsigned k;
    j = '0;
    k = 0;
    if (key_len > KEY_DEPTH) key_len = KEY_DEPTH;
    if (key_len == 0) key_len = 1;
    for (int n = 0; n < PermDepth; n++) sbox[n] = byte_t'(n);
    for (int n = 0; n < PermDepth; n++) begin
      j = j + sbox[n] + key_mem[k];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
      k++;
      if (k >= key_len) k = 0;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic byte_t next_keystream_byte();
    byte_t t;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    return sbox[byte_t'(sbox[idx_i] + sbox[idx_j])];
  endfunction

  function automatic void apply_rc4_command(logic [1:0] command, byte_t key_index,
                                            byte_t key_byte, byte_t key_len_m1,
                                            byte_t data_byte);
    case (command)
      CMD_KEY_WRITE: begin
        if (int'(key_index) < KEY_DEPTH) key_mem[key_index] = key_byte;
      end
      CMD_SCHEDULE: begin
        run_key_schedule(int'(key_len_m1) + 1);
      end
      CMD_DATA: begin
        cipher_bytes_q.push_back(data_byte ^ next_keystream_byte());
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < PermDepth; n++) begin
        sbox[n]    = byte_t'(n);
        key_mem[n] = '0;
      end
      idx_i = '0;
      idx_j = '0;
      cipher_bytes_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (cipher_bytes_q.size() == 0) begin
          $error("out_byte: expected none, actual 0x%02h", out_mon.out_byte);
          fail_count_o++;
        end else begin
          expected_byte = cipher_bytes_q.pop_front();
          if (out_mon.out_byte !== expected_byte) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h",
                   expected_byte, out_mon.out_byte);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_rc4_command(in_mon.command, in_mon.key_index, in_mon.key_byte,
                          in_mon.key_length_minus_one, in_mon.data_byte);
      end
      pending_o = cipher_bytes_q.size();
    end
  end

endmodule

@@ sim/tb_rc4_stream_cipher_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher_core
// Drives key writes, key schedules, cipher bytes and unused commands into the
// rc4 core with random gaps and result stalls; a checker beside the core
// predicts each cipher byte and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher_core import rc4_pkg::*; ();

  localparam int unsigned KeyDepth    = 256;
  localparam int unsigned ClkPeriodNs = 4;
  localparam int unsigned ItemTarget  = 1700;
  localparam int unsigned StallLimit  = 8000;
  localparam int unsigned DrainCycles = 16;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    byte_t      key_index;
    byte_t      key_byte;
    byte_t      key_length_minus_one;
    byte_t      data_byte;
  } rc4_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_fire = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned out_stall = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  bit          key_written [KeyDepth];
  int unsigned pending;
  int unsigned fail_count;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher_core #(.KEY_DEPTH(KeyDepth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rc4_stream_cipher_checker #(.KEY_DEPTH(KeyDepth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #(ClkPeriodNs / 2.0) clk_i = ~clk_i;

  function automatic int unsigned pick_idle(bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned key_prefix();
    int unsigned n;
    n = 0;
    while (n < KeyDepth && key_written[n]) n++;
    return n;
  endfunction

  function automatic rc4_item_t rand_item(logic [1:0] command);
    rc4_item_t it;
    it = rc4_item_t'({$urandom, $urandom});
    it.command = command;
    return it;
  endfunction

  always @(posedge clk_i) begin
    in_fire <= in_if.valid && in_if.ready;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("rc4_stream_cipher_core verification failed");
        $finish;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if ($urandom_range(199) == 0) out_quiet = ~out_quiet;
    if (out_stall != 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      out_stall = pick_idle(out_quiet);
    end
  end

  task automatic drive_item(rc4_item_t it);
    int unsigned gap;
    if ($urandom_range(59) == 0) in_quiet = ~in_quiet;
    gap = pick_idle(in_quiet);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid                <= 1'b1;
    in_if.command              <= it.command;
    in_if.key_index            <= it.key_index;
    in_if.key_byte             <= it.key_byte;
    in_if.key_length_minus_one <= it.key_length_minus_one;
    in_if.data_byte            <= it.data_byte;
    do @(negedge clk_i); while (!in_fire);
    if (it.command == CMD_KEY_WRITE) key_written[it.key_index] = 1'b1;
    if (it.command != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_key_byte(byte_t idx, byte_t val);
    rc4_item_t it;
    it = rand_item(CMD_KEY_WRITE);
    it.key_index = idx;
    it.key_byte  = val;
    drive_item(it);
  endtask

  task automatic send_schedule(byte_t len_m1);
    rc4_item_t it;
    it = rand_item(CMD_SCHEDULE);
    it.key_length_minus_one = len_m1;
    drive_item(it);
  endtask

  task automatic send_data(byte_t val);
    rc4_item_t it;
    it = rand_item(CMD_DATA);
    it.data_byte = val;
    drive_item(it);
  endtask

  task automatic send_key_sequence(int unsigned key_len);
    for (int unsigned k = 0; k < key_len; k++) send_key_byte(byte_t'(k), byte_t'($urandom));
    send_schedule(byte_t'(key_len - 1));
  endtask

  task automatic send_unused(rc4_item_t it);
    it.command = CMD_UNUSED;
    drive_item(it);
  endtask

  initial begin
    int unsigned key_len;
    int unsigned n_data;
    int unsigned prefix;
    in_if.valid                = 1'b0;
    in_if.command              = CMD_KEY_WRITE;
    in_if.key_index            = '0;
    in_if.key_byte             = '0;
    in_if.key_length_minus_one = '0;
    in_if.data_byte            = '0;
    rst_ni                     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity permutation before any schedule
    send_data(8'h00);
    send_data(ByteMax);
    send_unused('1);
    send_key_byte(8'h00, 8'h00);
    send_key_byte(8'h01, ByteMax);
    send_key_byte(ByteMax, 8'h5a);
    send_schedule(8'h00);
    send_data(8'h00);
    send_data(ByteMax);
    send_data(8'h3c);
    send_schedule(8'h01);
    send_data(8'h00);
    send_data(8'ha5);
    send_data(ByteMax);
    send_key_byte(8'h02, 8'h80);
    send_schedule(8'h02);
    send_data(ByteMax);
    send_unused('0);
    send_data(8'h00);
    send_schedule(8'h00);
    send_data(8'h7f);

    // full-length key first, then random traffic
    send_key_sequence(KeyDepth);
    repeat (20) send_data(byte_t'($urandom));
    while (items_sent < ItemTarget) begin
      if ($urandom_range(9) < 7) begin
        key_len = ($urandom_range(19) == 0) ? $urandom_range(17, KeyDepth)
                                            : $urandom_range(1, 16);
        send_key_sequence(key_len);
        n_data = ($urandom_range(15) == 0) ? $urandom_range(100, 250)
                                           : $urandom_range(1, 40);
        repeat (n_data) send_data(byte_t'($urandom));
      end else begin
        case ($urandom_range(3))
          0: send_key_byte(byte_t'($urandom), byte_t'($urandom));
          1: begin
            prefix = key_prefix();
            if (prefix != 0) send_schedule(byte_t'($urandom_range(0, prefix - 1)));
            else send_data(byte_t'($urandom));
          end
          2: send_data(byte_t'($urandom));
          default: send_unused(rand_item(CMD_UNUSED));
        endcase
      end
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rc4_stream_cipher_core verification clean");
    end else begin
      $display("rc4_stream_cipher_core verification failed");
    end
    $finish;
  end

endmodule
